@@ design/ccc_pkg.sv @@
package ccc_pkg;

	localparam int unsigned MaxChannelsDefault = 64;
	localparam int unsigned NodeIdBitsDefault  = 8;
	localparam int unsigned FieldBits          = 8;

	typedef enum logic [2:0] {
		KIND_ADD_CHANNEL = 3'd0,
		KIND_ADD_DEP     = 3'd1,
		KIND_REMOVE_DEP  = 3'd2,
		KIND_TEST_DEP    = 3'd3,
		KIND_REACHABLE   = 3'd4,
		KIND_CYCLIC      = 3'd5,
		KIND_HAS_CHANNEL = 3'd6
	} kind_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [FieldBits-1:0] a_from_node;
		logic [FieldBits-1:0] a_to_node;
		logic [FieldBits-1:0] b_from_node;
		logic [FieldBits-1:0] b_to_node;
	} req_t;

	typedef struct packed {
		logic answer;
		logic status;
	} rsp_t;

endpackage

@@ design/channel_dependency_cycle_checker.sv @@
// Channel dependency cycle checker: channel table plus adjacency bit matrix.
// Steps: a lookup sweep over the channel table, then channel items finish; removing or
// testing a dependency uses the source row; adding one first adds missing channels.
// Reachability adds up to count search levels of frontier row sweeps; the cycle test
// repeats that search once per channel. One item at a time; a stalled result holds it.
// Reset: a clearing pass zeroes all MAX_CHANNELS adjacency rows, count is zero.
module channel_dependency_cycle_checker import ccc_pkg::*; #(
	parameter int unsigned MAX_CHANNELS = MaxChannelsDefault,
	parameter int unsigned NODE_ID_BITS = NodeIdBitsDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned IW = $clog2(MAX_CHANNELS);
	localparam int unsigned CW = $clog2(MAX_CHANNELS + 1);
	localparam int unsigned KW = 2 * NODE_ID_BITS;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LOOK, S_DISP, S_ADDA, S_ADDB,
		S_ROWRD, S_ROWUSE, S_SWEEP, S_LEVEL, S_DONE
	} state_t;

	state_t state_q;
	req_t item_q;
	logic [KW-1:0] ka_q, kb_q;
	logic ha_q, hb_q;
	logic [IW-1:0] ia_q, ib_q, pend_idx_q, clr_q;
	logic [CW-1:0] cnt_q, idx_q, v_q;
	logic pend_q, pend_sel_q;
	logic [MAX_CHANNELS-1:0] frontier_q, visited_q, next_q;
	logic ans_q, sta_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	// key formation: node ids zero-extended, then cut to NODE_ID_BITS
	logic [15:0] af, at, bf, bt;
	logic [KW-1:0] ka_d, kb_d;
	assign af = {8'b0, req.a_from_node};
	assign at = {8'b0, req.a_to_node};
	assign bf = {8'b0, req.b_from_node};
	assign bt = {8'b0, req.b_to_node};
	assign ka_d = {af[NODE_ID_BITS-1:0], at[NODE_ID_BITS-1:0]};
	assign kb_d = {bf[NODE_ID_BITS-1:0], bt[NODE_ID_BITS-1:0]};

	// memories
	logic key_we, adj_we;
	logic [IW-1:0] key_waddr, adj_waddr, adj_raddr;
	logic [KW-1:0] key_wdata, key_rd;
	logic [MAX_CHANNELS-1:0] adj_wdata, adj_rd, ib_bit;

	assign ib_bit = {{(MAX_CHANNELS-1){1'b0}}, 1'b1} << ib_q;
	assign adj_raddr = (state_q == S_SWEEP) ? idx_q[IW-1:0] : ia_q;

	always_comb begin
		key_we = 1'b0;
		key_waddr = cnt_q[IW-1:0];
		key_wdata = ka_q;
		adj_we = 1'b0;
		adj_waddr = ia_q;
		adj_wdata = adj_rd | ib_bit;
		unique case (state_q)
			S_CLEAR: begin
				adj_we = 1'b1;
				adj_waddr = clr_q;
				adj_wdata = '0;
			end
			S_DISP: begin
				key_we = (kind_t'(item_q.kind) == KIND_ADD_CHANNEL) && !ha_q &&
					(cnt_q != CW'(MAX_CHANNELS));
			end
			S_ADDA: key_we = !ha_q;
			S_ADDB: begin
				key_we = !hb_q && (ka_q != kb_q);
				key_wdata = kb_q;
			end
			S_ROWUSE: begin
				adj_we = (kind_t'(item_q.kind) == KIND_ADD_DEP) ||
					(kind_t'(item_q.kind) == KIND_REMOVE_DEP);
				if (kind_t'(item_q.kind) == KIND_REMOVE_DEP) begin
					adj_wdata = adj_rd & ~ib_bit;
				end
			end
			default: ;
		endcase
	end

	ccc_ram #(.WIDTH(KW), .DEPTH(MAX_CHANNELS)) u_keys (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
		.raddr(idx_q[IW-1:0]), .rdata(key_rd)
	);

	ccc_ram #(.WIDTH(MAX_CHANNELS), .DEPTH(MAX_CHANNELS)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.raddr(adj_raddr), .rdata(adj_rd)
	);

	logic [CW:0] need_sum;
	logic [MAX_CHANNELS-1:0] fresh;
	assign need_sum = {1'b0, cnt_q} + (CW+1)'(!ha_q) + (CW+1)'(!(hb_q || ka_q == kb_q));
	assign fresh = next_q & ~visited_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			v_q <= '0;
			pend_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			frontier_q <= '0;
			visited_q <= '0;
		end else begin
			// S_DONE reloads the result register itself
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(MAX_CHANNELS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						item_q <= req;
						ka_q <= ka_d;
						kb_q <= kb_d;
						ha_q <= 1'b0;
						hb_q <= 1'b0;
						idx_q <= '0;
						pend_q <= 1'b0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					// key read pipelined one entry ahead of the compare
					if (idx_q < cnt_q) begin
						pend_q <= 1'b1;
						pend_idx_q <= idx_q[IW-1:0];
						idx_q <= idx_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q) begin
						if (key_rd == ka_q) begin
							ha_q <= 1'b1;
							ia_q <= pend_idx_q;
						end
						if (key_rd == kb_q) begin
							hb_q <= 1'b1;
							ib_q <= pend_idx_q;
						end
					end
					if (idx_q >= cnt_q && !pend_q) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					ans_q <= (kind_t'(item_q.kind) == KIND_HAS_CHANNEL) && ha_q;
					sta_q <= ((kind_t'(item_q.kind) == KIND_ADD_CHANNEL) && !ha_q &&
						(cnt_q == CW'(MAX_CHANNELS))) ||
						((kind_t'(item_q.kind) == KIND_ADD_DEP) &&
						(need_sum > (CW+1)'(MAX_CHANNELS)));
					unique case (kind_t'(item_q.kind)) inside
						KIND_ADD_CHANNEL: begin
							if (!ha_q && cnt_q != CW'(MAX_CHANNELS)) begin
								cnt_q <= cnt_q + 1'b1;
							end
							state_q <= S_DONE;
						end
						KIND_ADD_DEP: begin
							state_q <= (need_sum > (CW+1)'(MAX_CHANNELS)) ? S_DONE : S_ADDA;
						end
						KIND_REMOVE_DEP, KIND_TEST_DEP, KIND_REACHABLE: begin
							state_q <= (ha_q && hb_q) ? S_ROWRD : S_DONE;
						end
						KIND_CYCLIC: begin
							if (cnt_q != '0) begin
								v_q <= '0;
								ia_q <= '0;
								ib_q <= '0;
								state_q <= S_ROWRD;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_ADDA: begin
					if (!ha_q) begin
						ia_q <= cnt_q[IW-1:0];
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= S_ADDB;
				end
				S_ADDB: begin
					if (ka_q == kb_q) begin
						ib_q <= ia_q;
					end else if (!hb_q) begin
						ib_q <= cnt_q[IW-1:0];
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= S_ROWRD;
				end
				S_ROWRD: state_q <= S_ROWUSE;
				S_ROWUSE: begin
					if (kind_t'(item_q.kind) == KIND_TEST_DEP) begin
						ans_q <= |(adj_rd & ib_bit);
					end
					if (kind_t'(item_q.kind) == KIND_REACHABLE ||
					    kind_t'(item_q.kind) == KIND_CYCLIC) begin
						frontier_q <= adj_rd;
						visited_q <= adj_rd;
						next_q <= '0;
						idx_q <= '0;
						pend_q <= 1'b0;
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SWEEP: begin
					// OR together the rows of every frontier vertex
					if (idx_q < cnt_q) begin
						pend_q <= 1'b1;
						pend_sel_q <= frontier_q[idx_q[IW-1:0]];
						idx_q <= idx_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && pend_sel_q) begin
						next_q <= next_q | adj_rd;
					end
					if (idx_q >= cnt_q && !pend_q) begin
						state_q <= S_LEVEL;
					end
				end
				S_LEVEL: begin
					frontier_q <= fresh;
					visited_q <= visited_q | fresh;
					next_q <= '0;
					idx_q <= '0;
					if (fresh != '0) begin
						state_q <= S_SWEEP;
					end else if (kind_t'(item_q.kind) == KIND_REACHABLE) begin
						ans_q <= |(visited_q & ib_bit);
						state_q <= S_DONE;
					end else if (|(visited_q & ib_bit)) begin
						ans_q <= 1'b1;
						state_q <= S_DONE;
					end else if (v_q + 1'b1 == cnt_q) begin
						state_q <= S_DONE;
					end else begin
						v_q <= v_q + 1'b1;
						ia_q <= IW'(v_q + 1'b1);
						ib_q <= IW'(v_q + 1'b1);
						state_q <= S_ROWRD;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.answer <= ans_q;
						rsp_q.status <= sta_q;
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_CHANNELS)) else $error("channel count beyond table");

	a_status_no_answer: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status |-> !rsp_q.answer)
		else $error("refused add carries an answer");

	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == S_LOOK)
		else $error("accepted item did not start lookup");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !rsp_valid_q)
		else $error("result during clearing pass");

endmodule

@@ design/ccc_ram.sv @@
module ccc_ram import ccc_pkg::*; #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = MaxChannelsDefault,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
